// ----- hdl/tabulated_inverse_cdf_sampler_defines.svh -----
// Assertion macros used by the tabulated inverse-CDF sampler top level.
`ifndef TABULATED_INVERSE_CDF_SAMPLER_DEFINES_SVH
`define TABULATED_INVERSE_CDF_SAMPLER_DEFINES_SVH

// same-cycle implication, checked on clock, off while reset is high
`define TICS_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tics: same-cycle check failed");

// next-cycle implication
`define TICS_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tics: next-cycle check failed");

`endif

// ----- hdl/tics_pkg.sv -----
// Types and constants shared by the tabulated inverse-CDF sampler modules.
`default_nettype none
package tics_pkg;

   localparam int MOM_W      = 24;
   localparam int WEIGHT_W   = 16;
   localparam int FRAC_W     = 16;
   localparam int CUM_W      = 24;
   localparam int BIN_W      = 8;
   localparam int THRESH_W   = CUM_W + FRAC_W;
   localparam int DIFF_W     = MOM_W + 1;
   localparam int PROD_W     = DIFF_W + FRAC_W + 1;

   localparam int REQ_DATA_W = 72;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 32;
   localparam int RSP_USER_W = 1;

   localparam int USER_ACTION_BIT  = 0;
   localparam int USER_SEL_BIT     = 1;
   localparam int USER_RESTART_BIT = 2;

   localparam logic ACT_LOAD   = 1'b0;
   localparam logic ACT_SAMPLE = 1'b1;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      CMD_LOAD,
      CMD_SAMPLE,
      CMD_NULL_SAMPLE
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type              kind;
      logic                      sel;
      logic                      restart;
      logic signed [MOM_W-1:0]   momentum;
      logic [WEIGHT_W-1:0]       weight;
      logic [FRAC_W-1:0]         pick;
      logic [FRAC_W-1:0]         place;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_THRESH,
      ST_SEARCH,
      ST_FETCH,
      ST_DIFF,
      ST_MUL,
      ST_EMIT
   } back_state_type;

endpackage
`default_nettype wire

// ----- hdl/tics_front.sv -----
// Front end: takes requests, decodes them into commands and hands them to the queue.
`default_nettype none
module tics_front #(
   parameter int NUM_TABLES = 2
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [tics_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  wire logic [tics_pkg::REQ_USER_W-1:0]   req_tuser,
   output logic                                   push_valid,
   input  wire logic                              push_ready,
   output tics_pkg::cmd_type                      push_cmd
);
   import tics_pkg::*;

   logic    valid_ff, valid_in;
   cmd_type cmd_ff, cmd_in;
   logic    sel_ok;
   logic    keep;
   logic    take;

   always_comb begin
      sel_ok = (NUM_TABLES > 1) || (req_tuser[USER_SEL_BIT] == 1'b0);

      cmd_in.sel      = req_tuser[USER_SEL_BIT];
      cmd_in.restart  = req_tuser[USER_RESTART_BIT];
      cmd_in.momentum = req_tdata[MOM_W-1:0];
      cmd_in.weight   = req_tdata[MOM_W +: WEIGHT_W];
      cmd_in.pick     = req_tdata[MOM_W+WEIGHT_W +: FRAC_W];
      cmd_in.place    = req_tdata[MOM_W+WEIGHT_W+FRAC_W +: FRAC_W];

      if (req_tuser[USER_ACTION_BIT] == ACT_LOAD) begin
         cmd_in.kind = CMD_LOAD;
      end else if (sel_ok) begin
         cmd_in.kind = CMD_SAMPLE;
      end else begin
         cmd_in.kind = CMD_NULL_SAMPLE;
      end

      // loads to a table that does not exist are dropped here
      keep = (req_tuser[USER_ACTION_BIT] == ACT_SAMPLE) || sel_ok;

      req_tready = !valid_ff || push_ready;
      take       = req_tvalid && req_tready;
      valid_in   = req_tready ? (req_tvalid && keep) : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         cmd_ff <= cmd_in;
      end
   end

   assign push_valid = valid_ff;
   assign push_cmd   = cmd_ff;

endmodule
`default_nettype wire

// ----- hdl/tics_queue.sv -----
// Short command queue between the front and back ends.
`default_nettype none
module tics_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   output logic                   push_ready,
   input  wire tics_pkg::cmd_type push_cmd,
   output logic                   pop_valid,
   input  wire logic              pop_ready,
   output tics_pkg::cmd_type      pop_cmd
);
   import tics_pkg::*;

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   always_comb begin
      push_ready = count_ff != QCNT_W'(QUEUE_DEPTH);
      pop_valid  = count_ff != '0;
      pop_cmd    = entry_ff[rd_ptr_ff];
      do_push    = push_valid && push_ready;
      do_pop     = pop_valid && pop_ready;

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

// ----- hdl/tics_back.sv -----
// Back end: table memories, load append, binary search, interpolation and result register.
`default_nettype none
module tics_back #(
   parameter int TABLE_DEPTH = 256,
   parameter int NUM_TABLES  = 2
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              pop_valid,
   output logic                                   pop_ready,
   input  wire tics_pkg::cmd_type                 pop_cmd,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [tics_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   output logic [tics_pkg::RSP_USER_W-1:0]        rsp_tuser,
   output logic                                   emit_fire
);
   import tics_pkg::*;

   localparam int CNT_W     = $clog2(TABLE_DEPTH + 1);
   localparam int IDX_W     = $clog2(TABLE_DEPTH);
   localparam int MEM_DEPTH = NUM_TABLES * TABLE_DEPTH;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);
   localparam int TSEL_W    = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;

   // table memories
   logic signed [MOM_W-1:0] mom_mem [MEM_DEPTH];
   logic [CUM_W-1:0]        cum_mem [MEM_DEPTH];

   back_state_type          state_ff, state_in;
   logic [CNT_W-1:0]        cnt_ff [NUM_TABLES];
   logic [CNT_W-1:0]        cnt_in [NUM_TABLES];
   logic [CUM_W-1:0]        sum_ff [NUM_TABLES];
   logic [CUM_W-1:0]        sum_in [NUM_TABLES];
   logic                    rsp_valid_ff, rsp_valid_in;

   logic [ADDR_W-1:0]       base_ff, base_in;
   logic [CNT_W-1:0]        n_ff, n_in;
   logic [CUM_W-1:0]        total_ff, total_in;
   logic [FRAC_W-1:0]       pick_ff, pick_in;
   logic [FRAC_W-1:0]       place_ff, place_in;
   logic [THRESH_W-1:0]     thresh_ff, thresh_in;
   logic [CNT_W-1:0]        lo_ff, lo_in;
   logic [CNT_W-1:0]        hi_ff, hi_in;
   logic [CNT_W-1:0]        mid_ff, mid_in;
   logic [CNT_W-1:0]        bin_ff, bin_in;
   logic                    interp_ff, interp_in;
   logic                    empty_ff, empty_in;
   logic signed [MOM_W-1:0] x0_ff, x0_in;
   logic signed [DIFF_W-1:0] diff_ff, diff_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [RSP_USER_W-1:0]   rsp_user_ff, rsp_user_in;

   logic [CUM_W-1:0]        cum_rd_ff;
   logic signed [MOM_W-1:0] mom_a_rd_ff, mom_b_rd_ff;

   logic [TSEL_W-1:0]       tsel;
   logic [CNT_W-1:0]        cur_cnt;
   logic [CUM_W-1:0]        cur_sum;
   logic [ADDR_W-1:0]       base_now;
   logic [CNT_W-1:0]        load_cnt;
   logic [CUM_W-1:0]        load_prev;
   logic [CUM_W:0]          load_wide;
   logic [CUM_W-1:0]        load_sum;
   logic                    pop_fire;
   logic                    wr_en;
   logic [ADDR_W-1:0]       wr_addr;
   logic                    hit;
   logic [CNT_W-1:0]        lo_n, hi_n, mid_n;
   logic [CNT_W:0]          mid_sum;
   logic [ADDR_W-1:0]       cum_raddr;
   logic [CNT_W-1:0]        a_idx, b_idx;
   logic [ADDR_W-1:0]       mom_raddr_a, mom_raddr_b;
   logic [MOM_W-1:0]        out_mom;

   always_comb begin
      // request decode at the queue head
      tsel      = TSEL_W'(pop_cmd.sel);
      cur_cnt   = cnt_ff[tsel];
      cur_sum   = sum_ff[tsel];
      base_now  = ADDR_W'(tsel) * ADDR_W'(TABLE_DEPTH);
      load_cnt  = pop_cmd.restart ? '0 : cur_cnt;
      load_prev = pop_cmd.restart ? '0 : cur_sum;
      load_wide = {1'b0, load_prev} + (CUM_W+1)'(pop_cmd.weight);
      load_sum  = load_wide[CUM_W] ? '1 : load_wide[CUM_W-1:0];
      wr_addr   = base_now + ADDR_W'(load_cnt[IDX_W-1:0]);

      pop_ready = state_ff == ST_IDLE;
      pop_fire  = pop_valid && pop_ready;
      wr_en     = pop_fire && (pop_cmd.kind == CMD_LOAD) && (load_cnt < CNT_W'(TABLE_DEPTH));

      // one search probe per cycle
      hit     = {cum_rd_ff, {FRAC_W{1'b0}}} > thresh_ff;
      lo_n    = hit ? lo_ff : lo_ff + 1'b1 + (mid_ff - lo_ff);
      hi_n    = hit ? mid_ff : hi_ff;
      mid_sum = (CNT_W+1)'(lo_n) + (CNT_W+1)'(hi_n);
      mid_n   = mid_sum[CNT_W:1];

      cum_raddr = (state_ff == ST_SEARCH) ? base_ff + ADDR_W'(mid_n[IDX_W-1:0])
                                          : base_ff + ADDR_W'(mid_ff[IDX_W-1:0]);

      // neighbours of the found bin; clamp for first and past-the-end
      a_idx       = (lo_ff == '0) ? '0 : lo_ff - 1'b1;
      b_idx       = (lo_ff == n_ff) ? n_ff - 1'b1 : lo_ff;
      mom_raddr_a = base_ff + ADDR_W'(a_idx[IDX_W-1:0]);
      mom_raddr_b = base_ff + ADDR_W'(b_idx[IDX_W-1:0]);

      diff_in = {mom_b_rd_ff[MOM_W-1], mom_b_rd_ff} - {mom_a_rd_ff[MOM_W-1], mom_a_rd_ff};
      prod_in = diff_ff * $signed({1'b0, place_ff});
      out_mom = empty_ff ? '0 :
                interp_ff ? x0_ff + prod_ff[FRAC_W +: MOM_W] : x0_ff;

      state_in     = state_ff;
      cnt_in       = cnt_ff;
      sum_in       = sum_ff;
      base_in      = base_ff;
      n_in         = n_ff;
      total_in     = total_ff;
      pick_in      = pick_ff;
      place_in     = place_ff;
      thresh_in    = thresh_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      bin_in       = bin_ff;
      interp_in    = interp_ff;
      empty_in     = empty_ff;
      x0_in        = x0_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      emit_fire    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (pop_fire) begin
               case (pop_cmd.kind)
                  CMD_LOAD: begin
                     if (wr_en) begin
                        cnt_in[tsel] = load_cnt + 1'b1;
                        sum_in[tsel] = load_sum;
                     end
                  end
                  CMD_SAMPLE: begin
                     if (cur_cnt == '0) begin
                        empty_in = 1'b1;
                        state_in = ST_EMIT;
                     end else begin
                        empty_in = 1'b0;
                        n_in     = cur_cnt;
                        total_in = cur_sum;
                        base_in  = base_now;
                        pick_in  = pop_cmd.pick;
                        place_in = pop_cmd.place;
                        lo_in    = '0;
                        hi_in    = cur_cnt;
                        mid_in   = cur_cnt >> 1;
                        state_in = ST_THRESH;
                     end
                  end
                  default: begin
                     empty_in = 1'b1;
                     state_in = ST_EMIT;
                  end
               endcase
            end
         end
         ST_THRESH: begin
            thresh_in = THRESH_W'(pick_ff) * THRESH_W'(total_ff);
            state_in  = ST_SEARCH;
         end
         ST_SEARCH: begin
            lo_in  = lo_n;
            hi_in  = hi_n;
            mid_in = mid_n;
            if (lo_n == hi_n) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            bin_in    = b_idx;
            interp_in = (lo_ff != '0) && (lo_ff != n_ff);
            state_in  = ST_DIFF;
         end
         ST_DIFF: begin
            x0_in    = mom_a_rd_ff;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               emit_fire   = 1'b1;
               rsp_data_in = {(empty_ff ? {BIN_W{1'b0}} : BIN_W'(bin_ff)), out_mom};
               rsp_user_in = empty_ff;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = emit_fire ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int t = 0; t < NUM_TABLES; t++) begin
            cnt_ff[t] <= '0;
            sum_ff[t] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         sum_ff       <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff     <= base_in;
      n_ff        <= n_in;
      total_ff    <= total_in;
      pick_ff     <= pick_in;
      place_ff    <= place_in;
      thresh_ff   <= thresh_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mid_ff      <= mid_in;
      bin_ff      <= bin_in;
      interp_ff   <= interp_in;
      empty_ff    <= empty_in;
      x0_ff       <= x0_in;
      diff_ff     <= diff_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mom_mem[wr_addr] <= pop_cmd.momentum;
         cum_mem[wr_addr] <= load_sum;
      end
      cum_rd_ff   <= cum_mem[cum_raddr];
      mom_a_rd_ff <= mom_mem[mom_raddr_a];
      mom_b_rd_ff <= mom_mem[mom_raddr_b];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
`default_nettype wire

// ----- hdl/tabulated_inverse_cdf_sampler.sv -----
// Top level of the tabulated inverse-CDF sampler.
// Holds NUM_TABLES tables of TABLE_DEPTH (momentum, cumulative weight) entries. A load request
// appends one entry (restart begins the table again) and gives no response; a sample request
// gives one response: the bin found by a binary search of the cumulative weights, with the
// momentum interpolated inside the bin. Requests pass a decode register and a two-entry queue
// before the back end, so input keeps flowing while a response waits until the queue fills.
// The back end takes a load in its idle state; a sample passes the threshold, search, fetch,
// diff, mul and emit states, the search probing the cumulative memory's read port once per
// cycle; a sample of an empty or absent table goes from idle straight to emit.
`default_nettype none
`include "tabulated_inverse_cdf_sampler_defines.svh"
module tabulated_inverse_cdf_sampler #(
   parameter int TABLE_DEPTH = 256,
   parameter int NUM_TABLES  = 2
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // entry_momentum[23:0], entry_weight[39:24], uniform_pick[55:40], uniform_place[71:56]
   input  wire logic [tics_pkg::REQ_DATA_W-1:0]   req_tdata,
   // action[0], table_sel[1], restart[2]
   input  wire logic [tics_pkg::REQ_USER_W-1:0]   req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // momentum[23:0], bin_index[31:24]
   output logic [tics_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   // table_empty[0]
   output logic [tics_pkg::RSP_USER_W-1:0]        rsp_tuser
);
   import tics_pkg::*;

   logic    push_valid, push_ready;
   cmd_type push_cmd;
   logic    pop_valid, pop_ready;
   cmd_type pop_cmd;
   logic    emit_fire;

   tics_front #(
      .NUM_TABLES (NUM_TABLES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   tics_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   tics_back #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .NUM_TABLES  (NUM_TABLES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .emit_fire  (emit_fire)
   );

   `TICS_ASSERT_NXT(a_emit_shows, emit_fire, rsp_tvalid)
   `TICS_ASSERT_IMP(a_rise_from_emit, $rose(rsp_tvalid), $past(emit_fire))
   `TICS_ASSERT_IMP(a_empty_zero, rsp_tvalid && rsp_tuser[0], rsp_tdata == '0)
   `TICS_ASSERT_IMP(a_bin_range, rsp_tvalid && !rsp_tuser[0], {24'd0, rsp_tdata[31:24]} < TABLE_DEPTH)

endmodule
`default_nettype wire

// ----- tb/tabulated_inverse_cdf_sampler_test.sv -----
// Self-checking testbench for the tabulated inverse-CDF sampler: table loads, samples, checking.
`timescale 1ns / 100ps
module tabulated_inverse_cdf_sampler_test;
   import tics_pkg::*;

   localparam int TABLES = 2;
   localparam int DEPTH  = 256;

   typedef struct {
      logic                    action;
      logic                    sel;
      logic                    restart;
      logic signed [MOM_W-1:0] mom;
      logic [WEIGHT_W-1:0]     weight;
      logic [FRAC_W-1:0]       pick;
      logic [FRAC_W-1:0]       place;
   } request_type;

   typedef struct {
      logic [MOM_W-1:0] momentum;
      logic [BIN_W-1:0] bin;
      logic             empty;
   } sample_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // entry_momentum, entry_weight, uniform_pick, uniform_place (lowest bits first)
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   // action, table_sel, restart
   logic [REQ_USER_W-1:0] req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // momentum, bin_index
   logic [RSP_DATA_W-1:0] rsp_tdata;
   // table_empty
   logic [RSP_USER_W-1:0] rsp_tuser;

   request_type pending_requests[$];
   sample_type  due_samples[$];
   request_type on_bus;
   logic [REQ_USER_W-1:0] user_bits;

   logic signed [MOM_W-1:0] mom_tab [TABLES][DEPTH];
   logic [CUM_W-1:0]        cum_tab [TABLES][DEPTH];
   int unsigned             fill [TABLES];

   int unsigned accepted    = 0;
   int unsigned total_items = 0;
   int unsigned errors      = 0;
   int          req_gap     = 0;
   int          req_calm    = 0;
   int          rsp_stall   = 0;
   int          rsp_calm    = 0;

   tabulated_inverse_cdf_sampler #(
      .TABLE_DEPTH (DEPTH),
      .NUM_TABLES  (TABLES)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // mostly no pause, some short ones, a few long ones, and now and then a calm stretch with none
   function automatic int pause_len(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 199);
      if (r < 2) begin
         calm = $urandom_range(40, 160);
         return 0;
      end
      if (r < 120) return 0;
      if (r < 180) return $urandom_range(1, 3);
      if (r < 195) return $urandom_range(4, 9);
      return $urandom_range(10, 30);
   endfunction

   // table update on a load, expected draw on a sample
   task automatic apply_to_tables(input request_type rq);
      int unsigned cnt;
      int unsigned idx;
      logic [CUM_W:0] sum;
      logic [THRESH_W-1:0] thresh;
      longint x0, x1, prod;
      sample_type s;
      if (rq.action == ACT_LOAD) begin
         if (rq.restart) fill[rq.sel] = 0;
         cnt = fill[rq.sel];
         if (cnt < DEPTH) begin
            sum = (cnt == 0) ? '0 : {1'b0, cum_tab[rq.sel][cnt-1]};
            sum = sum + (CUM_W+1)'(rq.weight);
            if (sum[CUM_W]) sum = {1'b0, {CUM_W{1'b1}}};
            mom_tab[rq.sel][cnt] = rq.mom;
            cum_tab[rq.sel][cnt] = sum[CUM_W-1:0];
            fill[rq.sel] = cnt + 1;
         end
      end else begin
         cnt = fill[rq.sel];
         if (cnt == 0) begin
            s = '{momentum: '0, bin: '0, empty: 1'b1};
         end else begin
            thresh = THRESH_W'(rq.pick) * THRESH_W'(cum_tab[rq.sel][cnt-1]);
            idx = 0;
            while (idx < cnt && {cum_tab[rq.sel][idx], {FRAC_W{1'b0}}} <= thresh) idx++;
            s.empty = 1'b0;
            if (idx == cnt) begin
               s.momentum = mom_tab[rq.sel][cnt-1];
               s.bin      = BIN_W'(cnt - 1);
            end else if (idx == 0) begin
               s.momentum = mom_tab[rq.sel][0];
               s.bin      = '0;
            end else begin
               x0   = longint'(mom_tab[rq.sel][idx-1]);
               x1   = longint'(mom_tab[rq.sel][idx]);
               prod = (x1 - x0) * longint'(rq.place);
               s.momentum = MOM_W'(x0 + (prod >>> FRAC_W));
               s.bin      = BIN_W'(idx);
            end
         end
         due_samples.push_back(s);
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            apply_to_tables(on_bus);
            accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
               on_bus = pending_requests.pop_front();
               user_bits = '0;
               user_bits[USER_ACTION_BIT]  = on_bus.action;
               user_bits[USER_SEL_BIT]     = on_bus.sel;
               user_bits[USER_RESTART_BIT] = on_bus.restart;
               req_tdata  <= {on_bus.place, on_bus.pick, on_bus.weight, on_bus.mom};
               req_tuser  <= user_bits;
               req_tvalid <= 1'b1;
               req_gap = pause_len(req_calm);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      sample_type s;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (due_samples.size() == 0) begin
               $display("%0t: unexpected response momentum=%h bin=%0d empty=%b", $time,
                        rsp_tdata[MOM_W-1:0], rsp_tdata[MOM_W +: BIN_W], rsp_tuser[0]);
               errors++;
            end else begin
               s = due_samples.pop_front();
               if (rsp_tdata[MOM_W-1:0] !== s.momentum) begin
                  $display("%0t: momentum expected %h actual %h", $time, s.momentum,
                           rsp_tdata[MOM_W-1:0]);
                  errors++;
               end
               if (rsp_tdata[MOM_W +: BIN_W] !== s.bin) begin
                  $display("%0t: bin_index expected %0d actual %0d", $time, s.bin,
                           rsp_tdata[MOM_W +: BIN_W]);
                  errors++;
               end
               if (rsp_tuser[0] !== s.empty) begin
                  $display("%0t: table_empty expected %b actual %b", $time, s.empty,
                           rsp_tuser[0]);
                  errors++;
               end
            end
         end
         if (rsp_stall == 0) rsp_stall = pause_len(rsp_calm);
         rsp_tready <= (rsp_stall == 0);
         if (rsp_stall > 0) rsp_stall--;
      end
   end

   function automatic logic [MOM_W-1:0] rand_mom();
      case ($urandom_range(0, 9))
         0: return {1'b1, {(MOM_W-1){1'b0}}};
         1: return {1'b0, {(MOM_W-1){1'b1}}};
         2: return MOM_W'($urandom_range(0, 200)) - MOM_W'(100);
         default: return MOM_W'($urandom);
      endcase
   endfunction

   function automatic logic [WEIGHT_W-1:0] rand_weight();
      case ($urandom_range(0, 9))
         0, 1: return '0;
         2, 3: return WEIGHT_W'($urandom_range(1, 3));
         4: return '1;
         default: return WEIGHT_W'($urandom);
      endcase
   endfunction

   function automatic logic [FRAC_W-1:0] rand_frac();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return FRAC_W'($urandom);
      endcase
   endfunction

   task automatic push_load(input logic sel, input logic restart, input logic [MOM_W-1:0] mom,
                            input logic [WEIGHT_W-1:0] weight);
      request_type rq;
      rq = '{action: ACT_LOAD, sel: sel, restart: restart, mom: mom, weight: weight,
             pick: FRAC_W'($urandom), place: FRAC_W'($urandom)};
      pending_requests.push_back(rq);
   endtask

   task automatic push_sample(input logic sel, input logic restart,
                              input logic [FRAC_W-1:0] pick, input logic [FRAC_W-1:0] place);
      request_type rq;
      rq = '{action: ACT_SAMPLE, sel: sel, restart: restart, mom: MOM_W'($urandom),
             weight: WEIGHT_W'($urandom), pick: pick, place: place};
      pending_requests.push_back(rq);
   endtask

   initial begin
      int n;
      logic t;
      // directed: empty tables, zero weights, extremes, negative interpolation
      push_sample(1'b0, 1'b0, '1, '1);
      push_sample(1'b1, 1'b1, '0, '0);
      push_load(1'b0, 1'b1, 24'h800000, '0);
      push_sample(1'b0, 1'b0, '1, '0);
      push_load(1'b0, 1'b0, 24'h7FFFFF, '1);
      push_sample(1'b0, 1'b0, '0, '1);
      push_sample(1'b0, 1'b0, '1, '0);
      push_sample(1'b0, 1'b0, 16'h8000, 16'h8000);
      push_load(1'b1, 1'b1, 24'd100, '1);
      push_load(1'b1, 1'b0, -24'sd100, 16'd1);
      push_sample(1'b1, 1'b0, '0, '0);
      push_sample(1'b1, 1'b0, '1, '1);
      push_sample(1'b1, 1'b0, '1, 16'd1);
      push_load(1'b1, 1'b0, '0, '0);
      push_sample(1'b1, 1'b0, '1, 16'h8000);
      push_load(1'b0, 1'b1, 24'd5, '0);
      push_load(1'b0, 1'b0, 24'd7, '0);
      push_sample(1'b0, 1'b1, 16'h8000, '1);
      push_load(1'b0, 1'b1, 24'h7FFFFF, '1);
      push_load(1'b0, 1'b0, 24'h800000, '1);
      push_sample(1'b0, 1'b0, 16'h8000, '1);
      push_sample(1'b0, 1'b0, 16'h7FFF, '1);
      // fill each table past its depth; the surplus loads are dropped
      for (int tb_sel = 0; tb_sel < TABLES; tb_sel++) begin
         push_load(tb_sel[0], 1'b1, rand_mom(), rand_weight());
         for (int k = 0; k < DEPTH + 3; k++) begin
            push_load(tb_sel[0], 1'b0, rand_mom(), rand_weight());
            if ($urandom_range(0, 19) == 0) push_sample(tb_sel[0], 1'b0, rand_frac(), rand_frac());
         end
         push_sample(tb_sel[0], 1'b0, '1, '1);
         push_sample(tb_sel[0], 1'b0, '0, rand_frac());
         for (int k = 0; k < 8; k++) push_sample(tb_sel[0], 1'b0, rand_frac(), rand_frac());
      end
      // random: mostly restart-and-fill runs followed by draws, some noise
      while (pending_requests.size() < 1835) begin
         t = 1'($urandom_range(0, 1));
         case ($urandom_range(0, 9))
            0, 1: begin
               repeat ($urandom_range(1, 10)) begin
                  if ($urandom_range(0, 1)) push_sample(1'($urandom_range(0, 1)),
                                                      1'($urandom_range(0, 1)),
                                                      rand_frac(), rand_frac());
                  else push_load(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                 rand_mom(), rand_weight());
               end
            end
            2: repeat ($urandom_range(1, 4)) push_sample(t, 1'($urandom_range(0, 1)),
                                                        rand_frac(), rand_frac());
            default: begin
               n = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 60) : $urandom_range(0, 16);
               push_load(t, 1'b1, rand_mom(), rand_weight());
               repeat (n) push_load(t, 1'b0, rand_mom(), rand_weight());
               repeat ($urandom_range(1, 12)) push_sample(t, 1'b0, rand_frac(), rand_frac());
            end
         endcase
      end
      total_items = pending_requests.size();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      while (accepted < total_items) @(posedge clock);
      while (due_samples.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (errors == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/tics_pkg.sv
hdl/tics_front.sv
hdl/tics_queue.sv
hdl/tics_back.sv
hdl/tabulated_inverse_cdf_sampler.sv
tb/tabulated_inverse_cdf_sampler_test.sv
